FILE: rtl/hfd_pkg.sv
// shared constants and types for the host frame deframer
package hfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 4;

  localparam logic [BYTE_W-1:0] BYTE_READY = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_DIR   = 8'hD5;
  localparam logic [BYTE_W-1:0] BYTE_START = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;

  localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd254;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 4'd0,
    ST_NOTREADY = 4'd1,
    ST_HEADER   = 4'd2,
    ST_LCS      = 4'd3,
    ST_SHORT    = 4'd4,
    ST_DIR      = 4'd5,
    ST_LONG     = 4'd6,
    ST_DCS      = 4'd7,
    ST_POST     = 4'd8
  } status_t;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_HDR0    = 10'b00_0000_0010,
    PH_HDR1    = 10'b00_0000_0100,
    PH_HDR2    = 10'b00_0000_1000,
    PH_LEN     = 10'b00_0001_0000,
    PH_LCS     = 10'b00_0010_0000,
    PH_DIR     = 10'b00_0100_0000,
    PH_PAYLOAD = 10'b00_1000_0000,
    PH_DCS     = 10'b01_0000_0000,
    PH_POST    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic                frame_end;
    logic [BYTE_W-1:0]   payload_count;
    status_t             status;
    logic [BYTE_W-1:0]   payload_byte;
  } result_t;

endpackage

FILE: rtl/host_frame_deframer_checksum.sv
// host frame deframer: checks a controller response frame and streams its payload
//
// in_*  : one byte of a bus read per transaction; in_tuser marks the first byte
// out_* : one result per payload byte (out_tlast low) and one final status result
//         (out_tlast high) carrying status and payload count
// cfg_* : writes payload_capacity (reset 254); always ready, write only while idle
// a byte is checked in the cycle it is accepted; its result is registered in the
// output register, or in the skid register while the receiver stalls
// throughput is one byte per cycle while in_tready is high, set by the frame state machine
// bytes that give no result (header, length, checksums) are taken at that rate too
// an output register plus a one-entry skid register part the two channels:
// while the receiver stalls, bytes are still taken until one more result lands
// in the skid register; in_tready then stays low until the held result is taken
// and rises again the cycle after
// synchronous active-low reset returns the parser to idle, empties both result
// registers and restores payload_capacity to 254
// after an error or the postamble, bytes are ignored until the next first byte
module host_frame_deframer_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // first_of_read
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // payload_byte[7:0], status[11:8], payload_count[19:12], zero
  output logic        out_tlast,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // payload_capacity
);

  hfd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       frame_length_r, frame_length_nxt;
  logic [7:0]       data_sum_r, data_sum_nxt;
  logic [7:0]       bytes_seen_r, bytes_seen_nxt;
  logic [7:0]       capacity_r;

  hfd_pkg::result_t res;
  logic             res_valid;
  hfd_pkg::result_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  logic             in_acc;
  logic [7:0]       len_m1;
  logic [7:0]       sum_add;
  logic [7:0]       seen_inc;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign len_m1    = frame_length_r - 8'd1;
  assign sum_add   = data_sum_r + in_tdata;
  assign seen_inc  = bytes_seen_r + 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    data_sum_nxt     = data_sum_r;
    bytes_seen_nxt   = bytes_seen_r;
    res_valid        = 1'b0;
    res.frame_end     = 1'b1;
    res.payload_count = 8'd0;
    res.status        = hfd_pkg::ST_OK;
    res.payload_byte  = 8'd0;
    if (in_acc) begin
      if (in_tuser) begin
        frame_length_nxt = 8'd0;
        data_sum_nxt     = 8'd0;
        bytes_seen_nxt   = 8'd0;
        if (in_tdata != hfd_pkg::BYTE_READY) begin
          res_valid  = 1'b1;
          res.status = hfd_pkg::ST_NOTREADY;
          phase_nxt  = hfd_pkg::PH_IDLE;
        end else begin
          phase_nxt = hfd_pkg::PH_HDR0;
        end
      end else begin
        case (phase_r)
          hfd_pkg::PH_HDR0, hfd_pkg::PH_HDR1: begin
            if (in_tdata != hfd_pkg::BYTE_ZERO) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_HEADER;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else if (phase_r == hfd_pkg::PH_HDR0) begin
              phase_nxt = hfd_pkg::PH_HDR1;
            end else begin
              phase_nxt = hfd_pkg::PH_HDR2;
            end
          end
          hfd_pkg::PH_HDR2: begin
            if (in_tdata != hfd_pkg::BYTE_START) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_HEADER;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else begin
              phase_nxt = hfd_pkg::PH_LEN;
            end
          end
          hfd_pkg::PH_LEN: begin
            frame_length_nxt = in_tdata;
            phase_nxt        = hfd_pkg::PH_LCS;
          end
          hfd_pkg::PH_LCS: begin
            if ((frame_length_r + in_tdata) != 8'd0) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_LCS;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else if (frame_length_r < 8'd2) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_SHORT;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else begin
              phase_nxt = hfd_pkg::PH_DIR;
            end
          end
          hfd_pkg::PH_DIR: begin
            if (in_tdata != hfd_pkg::BYTE_DIR) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_DIR;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else if (len_m1 > capacity_r) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_LONG;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else begin
              data_sum_nxt   = in_tdata;
              bytes_seen_nxt = 8'd0;
              phase_nxt      = hfd_pkg::PH_PAYLOAD;
            end
          end
          hfd_pkg::PH_PAYLOAD: begin
            data_sum_nxt     = sum_add;
            bytes_seen_nxt   = seen_inc;
            if (seen_inc >= len_m1) begin
              phase_nxt = hfd_pkg::PH_DCS;
            end
            res_valid        = 1'b1;
            res.frame_end    = 1'b0;
            res.payload_byte = in_tdata;
          end
          hfd_pkg::PH_DCS: begin
            if (sum_add != 8'd0) begin
              res_valid  = 1'b1;
              res.status = hfd_pkg::ST_DCS;
              phase_nxt  = hfd_pkg::PH_IDLE;
            end else begin
              phase_nxt = hfd_pkg::PH_POST;
            end
          end
          hfd_pkg::PH_POST: begin
            res_valid = 1'b1;
            phase_nxt = hfd_pkg::PH_IDLE;
            if (in_tdata != hfd_pkg::BYTE_ZERO) begin
              res.status = hfd_pkg::ST_POST;
            end else begin
              res.payload_count = len_m1;
            end
          end
          default: begin
            phase_nxt = hfd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= hfd_pkg::PH_IDLE;
      frame_length_r <= 8'd0;
      data_sum_r     <= 8'd0;
      bytes_seen_r   <= 8'd0;
      capacity_r     <= hfd_pkg::CAPACITY_RESET;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      data_sum_r     <= data_sum_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.frame_end;
  assign out_tdata  = {4'd0, out_r.payload_count, out_r.status, out_r.payload_byte};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_final_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_end) |-> (out_r.payload_byte == 8'd0))
    else $error("final result carries a payload byte");

  a_byte_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.frame_end) |->
      (out_r.status == hfd_pkg::ST_OK && out_r.payload_count == 8'd0))
    else $error("payload result carries status or count");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_end && out_r.status == hfd_pkg::ST_OK) |->
      (out_r.payload_count != 8'd0))
    else $error("ok final result with zero payload count");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hfd_pkg::PH_PAYLOAD) |->
      ({1'b0, bytes_seen_r} + 9'd1 < {1'b0, frame_length_r}))
    else $error("payload counter passed frame length");

endmodule
